/* hdl/assert_macros.svh */
// Assertion macros for the RTL files; included by http_response_framer.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define HRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define HRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/hrf_pkg.sv */
`default_nettype none
package hrf_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } hrf_in_t;

  typedef struct packed {
    logic        consumed;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        head_done;
    logic        done_res;
    logic [1:0]  error_code;
    logic [9:0]  status_code;
    logic        length_known;
    logic [39:0] content_length;
    logic        is_chunked;
    logic        close_after;
    logic [19:0] retry_seconds;
  } hrf_out_t;

  typedef struct packed {
    logic [9:0]  status;
    logic        known;
    logic [39:0] length;
    logic        chunked;
    logic        close_req;
    logic [19:0] retry;
  } hrf_head_res_t;

  typedef enum logic [2:0] {
    PH_HEAD, PH_LEN, PH_CHUNK, PH_CLOSE, PH_DONE
  } hrf_phase_t;

  typedef enum logic [2:0] {
    EV_NONE, EV_BAD, EV_LEN, EV_CHUNK, EV_CLOSE, EV_DONE
  } hrf_ev_t;

  typedef enum logic [2:0] {
    CK_SIZE, CK_EXT, CK_SIZE_LF, CK_DATA, CK_DATA_CR, CK_DATA_LF, CK_TRAILER
  } hrf_ck_t;

  typedef enum logic [2:0] {
    CKR_TAKE, CKR_DATA, CKR_END, CKR_BAD, CKR_BIG
  } hrf_ck_res_t;

  typedef enum logic [2:0] {
    HDR_CLEN, HDR_TE, HDR_CONN, HDR_RETRY, HDR_NONE
  } hrf_hdr_t;

  typedef enum logic [1:0] {
    LP_SKIP, LP_TOKEN, LP_AFTER
  } hrf_lp_t;

  typedef struct packed {
    logic        first_line;
    logic        bad;
    logic        v10;
    logic        cr_wait;
    logic        in_value;
    logic        val_started;
    logic        ws_wait;
    logic        broken;
    logic        tok_miss;
    logic        found;
    logic [4:0]  name_pos;
    logic [3:0]  cands;
    hrf_hdr_t    hdr;
    logic [3:0]  digits;
    hrf_lp_t     list_ph;
    logic [2:0]  tok_pos;
    logic [39:0] num;
  } hrf_scan_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_BAD  = 2'd1;
  localparam logic [1:0] ERR_BIG  = 2'd2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  function automatic logic is_sp(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic [7:0] to_low(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
  endfunction

endpackage
`default_nettype wire

/* hdl/hrf_head.sv */
`default_nettype none
module hrf_head import hrf_pkg::*; #(
  parameter int HEAD_BYTES_MAX = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          restart,
  input  logic          step,
  input  logic [7:0]    c,
  output logic          full,
  output hrf_ev_t       ev,
  output hrf_head_res_t res_next,
  output logic [39:0]   body_len
);

  localparam int HC_W = $clog2(HEAD_BYTES_MAX);

  localparam logic [8*17-1:0] HN_CLEN  = {"content-length", 24'h0};
  localparam logic [8*17-1:0] HN_TE    = "transfer-encoding";
  localparam logic [8*17-1:0] HN_CONN  = {"connection", 56'h0};
  localparam logic [8*17-1:0] HN_RETRY = {"retry-after", 48'h0};
  localparam logic [4:0] HDR_LEN [4] = '{5'd14, 5'd17, 5'd10, 5'd11};
  localparam logic [55:0] LEAD      = "http/1.";
  localparam logic [55:0] W_CHUNKED = "chunked";
  localparam logic [39:0] W_CLOSE   = "close";

  logic [HC_W-1:0] head_count, head_count_next;
  logic [15:0]     recent, recent_next;
  hrf_scan_t       scan, scan_next;
  logic [9:0]      status, status_next;
  logic [40:0]     length, length_next;
  logic [1:0]      flags, flags_next;
  logic [19:0]     retry, retry_next;

  function automatic logic [7:0] name_char(input int i, input logic [4:0] pos);
    logic [8*17-1:0] w;
    logic [7:0]      r;
    case (i)
      0:       w = HN_CLEN;
      1:       w = HN_TE;
      2:       w = HN_CONN;
      default: w = HN_RETRY;
    endcase
    r = 8'h00;
    if (pos < 5'd17) r = w[8*(16 - int'(pos)) +: 8];
    return r;
  endfunction

  function automatic logic [7:0] word_char(input logic te, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'h00;
    if (te && pos < 3'd7) r = W_CHUNKED[8*(6 - int'(pos)) +: 8];
    else if (!te && pos < 3'd5) r = W_CLOSE[8*(4 - int'(pos)) +: 8];
    return r;
  endfunction

  function automatic hrf_scan_t value_begin(input hrf_scan_t si);
    hrf_scan_t s;
    s = si;
    s.val_started = 1'b0;
    s.ws_wait     = 1'b0;
    s.broken      = 1'b0;
    s.tok_miss    = 1'b0;
    s.found       = 1'b0;
    s.digits      = 4'd0;
    s.num         = 40'd0;
    s.list_ph     = LP_SKIP;
    s.tok_pos     = 3'd0;
    return s;
  endfunction

  function automatic hrf_scan_t line_clear(input hrf_scan_t si);
    hrf_scan_t s;
    s = value_begin(si);
    s.cr_wait  = 1'b0;
    s.in_value = 1'b0;
    s.name_pos = 5'd0;
    s.cands    = 4'hF;
    s.hdr      = HDR_NONE;
    return s;
  endfunction

  function automatic hrf_scan_t scan_init();
    hrf_scan_t s;
    s = '0;
    s.first_line = 1'b1;
    return line_clear(s);
  endfunction

  function automatic hrf_scan_t list_eval(input hrf_scan_t si);
    hrf_scan_t s;
    s = si;
    if (!s.tok_miss && s.tok_pos == ((s.hdr == HDR_TE) ? 3'd7 : 3'd5)) s.found = 1'b1;
    return s;
  endfunction

  function automatic hrf_scan_t num_char(input hrf_scan_t si, input logic [7:0] cc);
    hrf_scan_t   s;
    logic [39:0] t10;
    s   = si;
    t10 = (s.num << 3) + (s.num << 1) + {36'd0, cc[3:0]};
    if (is_sp(cc)) begin
      if (s.val_started) s.ws_wait = 1'b1;
    end else begin
      if (s.ws_wait) s.broken = 1'b1;
      s.val_started = 1'b1;
      if (s.hdr == HDR_CLEN) begin
        if (!is_dig(cc) || s.digits >= 4'd12) begin
          s.broken = 1'b1;
        end else begin
          s.num    = t10;
          s.digits = s.digits + 4'd1;
        end
      end else if (!s.broken) begin
        if (is_dig(cc) && s.num < 40'd100000) s.num = t10;
        else s.broken = 1'b1;
      end
    end
    return s;
  endfunction

  function automatic hrf_scan_t list_char(input hrf_scan_t si, input logic [7:0] cc);
    hrf_scan_t s;
    logic      te;
    logic      go;
    s  = si;
    te = (s.hdr == HDR_TE);
    go = 1'b1;
    if (s.list_ph == LP_AFTER) begin
      if (cc == CH_COMMA) s.list_ph = LP_SKIP;
      go = 1'b0;
    end else if (s.list_ph == LP_SKIP) begin
      if (is_sp(cc) || cc == CH_COMMA) begin
        go = 1'b0;
      end else if (cc == CH_SEMI) begin
        s.list_ph = LP_AFTER;
        go = 1'b0;
      end else begin
        s.list_ph  = LP_TOKEN;
        s.tok_pos  = 3'd0;
        s.tok_miss = 1'b0;
        s.ws_wait  = 1'b0;
      end
    end
    if (go) begin
      if (cc == CH_COMMA || cc == CH_SEMI) begin
        s = list_eval(s);
        s.list_ph = (cc == CH_COMMA) ? LP_SKIP : LP_AFTER;
      end else if (is_sp(cc)) begin
        s.ws_wait = 1'b1;
      end else begin
        if (s.ws_wait) s.tok_miss = 1'b1;
        if (s.tok_pos < (te ? 3'd7 : 3'd5) && to_low(cc) == word_char(te, s.tok_pos))
          s.tok_pos = s.tok_pos + 3'd1;
        else
          s.tok_miss = 1'b1;
      end
    end
    return s;
  endfunction

  function automatic hrf_scan_t content_char(input hrf_scan_t si, input logic [7:0] cc);
    hrf_scan_t s;
    s = si;
    if (s.in_value) begin
      if (s.hdr == HDR_CLEN || s.hdr == HDR_RETRY) s = num_char(s, cc);
      else if (s.hdr == HDR_TE || s.hdr == HDR_CONN) s = list_char(s, cc);
    end else if (cc == CH_COLON) begin
      if (s.name_pos == 5'd0) s.bad = 1'b1;
      s.hdr = HDR_NONE;
      for (int i = 0; i < 4; i++) begin
        if (s.cands[i] && s.name_pos == HDR_LEN[i]) s.hdr = hrf_hdr_t'(3'(i));
      end
      s.in_value = 1'b1;
      s = value_begin(s);
    end else begin
      if (cc < 8'h21 || cc > 8'h7E) s.bad = 1'b1;
      for (int i = 0; i < 4; i++) begin
        if (s.cands[i] && (s.name_pos >= HDR_LEN[i] ||
                           to_low(cc) != name_char(i, s.name_pos)))
          s.cands[i] = 1'b0;
      end
      if (s.name_pos < 5'd31) s.name_pos = s.name_pos + 5'd1;
    end
    return s;
  endfunction

  // Fold a held CR into the line as an ordinary content byte.
  function automatic hrf_scan_t cr_char(input hrf_scan_t si);
    hrf_scan_t s;
    s = si;
    if (s.in_value) begin
      if (s.hdr == HDR_CLEN || s.hdr == HDR_RETRY) begin
        s.val_started = 1'b1;
        s.broken      = 1'b1;
      end else if ((s.hdr == HDR_TE || s.hdr == HDR_CONN) && s.list_ph != LP_AFTER) begin
        if (s.list_ph == LP_SKIP) begin
          s.tok_pos = 3'd0;
          s.ws_wait = 1'b0;
        end
        s.list_ph  = LP_TOKEN;
        s.tok_miss = 1'b1;
      end
    end else begin
      s.bad   = 1'b1;
      s.cands = 4'h0;
      if (s.name_pos < 5'd31) s.name_pos = s.name_pos + 5'd1;
    end
    return s;
  endfunction

  logic        is_end;
  logic [3:0]  pos;
  logic [13:0] st_wide;

  assign full = head_count >= HC_W'(HEAD_BYTES_MAX - 1);
  assign is_end = (c == CH_LF) &&
                  ((head_count >= HC_W'(1) && recent[7:0] == CH_LF) ||
                   (head_count >= HC_W'(2) && recent[7:0] == CH_CR && recent[15:8] == CH_LF));
  assign pos = head_count[3:0];
  assign st_wide = ({4'd0, status} << 3) + ({4'd0, status} << 1) + {10'd0, c[3:0]};

  always_comb begin
    head_count_next = head_count;
    recent_next     = recent;
    scan_next       = scan;
    status_next     = status;
    length_next     = length;
    flags_next      = flags;
    retry_next      = retry;
    ev              = EV_NONE;
    if (restart) begin
      head_count_next = '0;
      recent_next     = '0;
      scan_next       = scan_init();
      status_next     = '0;
      length_next     = '0;
      flags_next      = '0;
      retry_next      = '0;
    end else if (step) begin
      head_count_next = head_count + HC_W'(1);
      recent_next     = {recent[7:0], c};
      if (is_end) begin
        if (scan.bad || status == 10'd101) begin
          ev = EV_BAD;
        end else begin
          flags_next = flags | {scan.v10, 1'b0};
          if (status < 10'd200) begin
            head_count_next = '0;
            recent_next     = '0;
            scan_next       = scan_init();
            status_next     = '0;
            length_next     = '0;
            flags_next      = '0;
            retry_next      = '0;
          end else if (status == 10'd204 || status == 10'd304 ||
                       (!flags_next[0] && length[40] && length[39:0] == 40'd0)) begin
            ev = EV_DONE;
          end else if (flags_next[0]) begin
            ev = EV_CHUNK;
          end else if (length[40]) begin
            ev = EV_LEN;
          end else begin
            ev = EV_CLOSE;
          end
        end
      end else if (scan.first_line) begin
        if (head_count < HC_W'(12)) begin
          if (pos < 4'd7) begin
            if (to_low(c) != LEAD[8*(6 - int'(pos)) +: 8]) scan_next.bad = 1'b1;
          end else if (pos == 4'd7) begin
            if (c == 8'h30) scan_next.v10 = 1'b1;
            else if (c != 8'h31) scan_next.bad = 1'b1;
          end else if (pos == 4'd8) begin
            if (c != CH_SP) scan_next.bad = 1'b1;
          end else if (!is_dig(c)) begin
            scan_next.bad = 1'b1;
          end else begin
            status_next = st_wide[9:0];
            if (pos == 4'd11 && status_next < 10'd100) scan_next.bad = 1'b1;
          end
        end
        if (c == CH_LF) begin
          scan_next = line_clear(scan_next);
          scan_next.first_line = 1'b0;
        end
      end else if (c == CH_LF) begin
        if (!scan_next.in_value) scan_next.bad = 1'b1;
        if (!scan_next.bad) begin
          case (scan_next.hdr)
            HDR_CLEN: begin
              if (scan_next.digits == 4'd0 || scan_next.broken)
                scan_next.bad = 1'b1;
              else if (length[40] && length[39:0] != scan_next.num)
                scan_next.bad = 1'b1;
              else
                length_next = {1'b1, scan_next.num};
            end
            HDR_TE, HDR_CONN: begin
              if (scan_next.list_ph == LP_TOKEN) scan_next = list_eval(scan_next);
              if (scan_next.hdr == HDR_TE) begin
                if (!scan_next.found) scan_next.bad = 1'b1;
                else flags_next[0] = 1'b1;
              end else if (scan_next.found) begin
                flags_next[1] = 1'b1;
              end
            end
            HDR_RETRY: retry_next = scan_next.broken ? 20'd0 : scan_next.num[19:0];
            default: ;
          endcase
        end
        scan_next = line_clear(scan_next);
      end else if (c == CH_CR) begin
        if (scan.cr_wait) scan_next = cr_char(scan_next);
        scan_next.cr_wait = 1'b1;
      end else begin
        if (scan.cr_wait) scan_next = cr_char(scan_next);
        scan_next.cr_wait = 1'b0;
        scan_next = content_char(scan_next, c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_count <= '0;
      recent     <= '0;
      scan       <= scan_init();
      status     <= '0;
      length     <= '0;
      flags      <= '0;
      retry      <= '0;
    end else begin
      head_count <= head_count_next;
      recent     <= recent_next;
      scan       <= scan_next;
      status     <= status_next;
      length     <= length_next;
      flags      <= flags_next;
      retry      <= retry_next;
    end
  end

  assign res_next.status    = status_next;
  assign res_next.known     = length_next[40];
  assign res_next.length    = length_next[39:0];
  assign res_next.chunked   = flags_next[0];
  assign res_next.close_req = flags_next[1];
  assign res_next.retry     = retry_next;
  assign body_len           = length[39:0];

endmodule
`default_nettype wire

/* hdl/hrf_chunk.sv */
`default_nettype none
module hrf_chunk import hrf_pkg::*; #(
  parameter int TRAILER_LINE_MAX = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        restart,
  input  logic        step,
  input  logic [7:0]  c,
  output hrf_ck_res_t res
);

  localparam int LL_W = $clog2(TRAILER_LINE_MAX + 2);

  hrf_ck_t         ck, ck_next;
  logic [35:0]     left, left_next;
  logic [LL_W-1:0] ll, ll_next;

  logic            hex_ok;
  logic [3:0]      hex_v;
  logic            size_end;
  logic [35:0]     left_dec;
  logic [LL_W:0]   ll_inc;

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = c[3:0];
    if (is_dig(c)) hex_v = c[3:0];
    else if (to_low(c) >= 8'h61 && to_low(c) <= 8'h66) hex_v = c[3:0] + 4'd9;
    else hex_ok = 1'b0;
  end

  assign left_dec = (left != 36'd0) ? left - 36'd1 : 36'd0;
  assign ll_inc   = {1'b0, ll} + (LL_W + 1)'(1);

  always_comb begin
    ck_next   = ck;
    left_next = left;
    ll_next   = ll;
    res       = CKR_TAKE;
    size_end  = 1'b0;
    if (restart) begin
      ck_next   = CK_SIZE;
      left_next = '0;
      ll_next   = '0;
    end else if (step) begin
      unique case (ck)
        CK_SIZE: begin
          if (hex_ok) begin
            if (left > 36'h0FFFFFFF) begin
              res = CKR_BAD;
            end else begin
              left_next = {left[31:0], hex_v};
              ll_next   = LL_W'(1);
            end
          end else if (ll == '0) begin
            res = CKR_BAD;
          end else if (c == CH_SEMI || is_sp(c)) begin
            ck_next = CK_EXT;
          end else if (c == CH_CR) begin
            ck_next = CK_SIZE_LF;
          end else if (c == CH_LF) begin
            size_end = 1'b1;
          end else begin
            res = CKR_BAD;
          end
        end
        CK_EXT: begin
          if (c == CH_CR) ck_next = CK_SIZE_LF;
          else if (c == CH_LF) size_end = 1'b1;
        end
        CK_SIZE_LF: begin
          if (c != CH_LF) res = CKR_BAD;
          else size_end = 1'b1;
        end
        CK_DATA: begin
          res       = CKR_DATA;
          left_next = left_dec;
          if (left_dec == 36'd0) ck_next = CK_DATA_CR;
        end
        CK_DATA_CR: begin
          if (c == CH_CR) ck_next = CK_DATA_LF;
          else if (c == CH_LF) ck_next = CK_SIZE;
          else res = CKR_BAD;
        end
        CK_DATA_LF: begin
          if (c != CH_LF) res = CKR_BAD;
          else ck_next = CK_SIZE;
        end
        CK_TRAILER: begin
          if (c == CH_LF) begin
            if (ll == '0) res = CKR_END;
            else ll_next = '0;
          end else if (c != CH_CR) begin
            ll_next = ll_inc[LL_W-1:0];
            if (ll_inc > (LL_W + 1)'(TRAILER_LINE_MAX)) res = CKR_BIG;
          end
        end
        default: res = CKR_BAD;
      endcase
      if (size_end) begin
        ll_next = '0;
        ck_next = (left != 36'd0) ? CK_DATA : CK_TRAILER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ck   <= CK_SIZE;
      left <= '0;
      ll   <= '0;
    end else begin
      ck   <= ck_next;
      left <= left_next;
      ll   <= ll_next;
    end
  end

endmodule
`default_nettype wire

/* hdl/http_response_framer.sv */
// HTTP/1.x response framer.
// The req channel carries one transaction per received byte: kind 0 is a
// response byte, kind 1 restarts the parser for a new response. The rsp
// channel returns exactly one transaction per req transaction, in order: the
// consumed and body flags, the payload byte, header-done and done marks, the
// error code, and the decoded header fields once the final header is in.
// The result of an accepted byte is registered and shown on rsp from the
// next cycle. Throughput is one byte per cycle unless the receiver stalls;
// each byte is decoded in a single step before the result register, by the
// header scanner in the header phase or the chunk decoder in chunked bodies.
// While the receiver stalls, the result register holds its transaction and
// req is stalled only when that register is full and stalled.
// Reset (synchronous, active high) empties the result register and returns
// the parser to the status-line start with no error; a restart transaction
// also returns the parser there with no error and answers with an all-zero result.
// Errors stay until a restart. An until-close body ends only on restart.
`default_nettype none
`include "assert_macros.svh"
module http_response_framer import hrf_pkg::*; #(
  parameter int HEAD_BYTES_MAX   = 4096,
  parameter int TRAILER_LINE_MAX = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  hrf_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output hrf_out_t rsp
);

  hrf_phase_t    phase, phase_next;
  logic [1:0]    error_flag, error_flag_next;
  logic [39:0]   body_count, body_count_next;
  hrf_out_t      res;

  logic          accept;
  logic          restart;
  logic          head_step;
  logic          chunk_step;
  logic          head_full;
  hrf_ev_t       ev;
  hrf_head_res_t hres;
  logic [39:0]   body_len;
  hrf_ck_res_t   ck_res;

  assign req_stall  = rsp_valid && rsp_stall;
  assign accept     = req_valid && !req_stall;
  assign restart    = accept && req.kind;
  assign head_step  = accept && !req.kind && error_flag == ERR_NONE &&
                      phase == PH_HEAD && !head_full;
  assign chunk_step = accept && !req.kind && error_flag == ERR_NONE && phase == PH_CHUNK;

  hrf_head #(
    .HEAD_BYTES_MAX(HEAD_BYTES_MAX)
  ) u_head (
    .clk      (clk),
    .rst      (rst),
    .restart  (restart),
    .step     (head_step),
    .c        (req.in_byte),
    .full     (head_full),
    .ev       (ev),
    .res_next (hres),
    .body_len (body_len)
  );

  hrf_chunk #(
    .TRAILER_LINE_MAX(TRAILER_LINE_MAX)
  ) u_chunk (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .step    (chunk_step),
    .c       (req.in_byte),
    .res     (ck_res)
  );

  always_comb begin
    phase_next      = phase;
    error_flag_next = error_flag;
    body_count_next = body_count;
    res             = '0;
    if (req.kind) begin
      phase_next      = PH_HEAD;
      error_flag_next = ERR_NONE;
      body_count_next = '0;
    end else if (error_flag == ERR_NONE) begin
      unique case (phase)
        PH_HEAD: begin
          if (head_full) begin
            error_flag_next = ERR_BIG;
          end else begin
            case (ev)
              EV_BAD:   error_flag_next = ERR_BAD;
              EV_LEN:   phase_next = PH_LEN;
              EV_CHUNK: phase_next = PH_CHUNK;
              EV_CLOSE: phase_next = PH_CLOSE;
              EV_DONE:  phase_next = PH_DONE;
              default:  ;
            endcase
            res.consumed  = (ev != EV_BAD);
            res.head_done = (ev == EV_LEN) || (ev == EV_CHUNK) ||
                            (ev == EV_CLOSE) || (ev == EV_DONE);
          end
        end
        PH_LEN: begin
          res.consumed    = 1'b1;
          res.body_valid  = 1'b1;
          body_count_next = body_count + 40'd1;
          if (body_count_next >= body_len) phase_next = PH_DONE;
        end
        PH_CHUNK: begin
          case (ck_res)
            CKR_BAD: error_flag_next = ERR_BAD;
            CKR_BIG: error_flag_next = ERR_BIG;
            CKR_END: phase_next = PH_DONE;
            default: ;
          endcase
          res.consumed   = (ck_res != CKR_BAD) && (ck_res != CKR_BIG);
          res.body_valid = (ck_res == CKR_DATA);
        end
        PH_CLOSE: begin
          res.consumed   = 1'b1;
          res.body_valid = 1'b1;
        end
        default: ;
      endcase
    end
    res.body_byte  = res.body_valid ? req.in_byte : 8'd0;
    res.done_res   = (phase_next == PH_DONE);
    res.error_code = error_flag_next;
    if (phase_next != PH_HEAD) begin
      res.status_code    = hres.status;
      res.length_known   = hres.known;
      res.content_length = hres.known ? hres.length : 40'd0;
      res.is_chunked     = hres.chunked;
      res.close_after    = hres.close_req;
      res.retry_seconds  = hres.retry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEAD;
      error_flag <= ERR_NONE;
      body_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        error_flag <= error_flag_next;
        body_count <= body_count_next;
        rsp_valid  <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) rsp <= res;
  end

  `HRF_ASSERT_NEXT(a_err_sticky, error_flag != ERR_NONE && !restart, error_flag == $past(error_flag), "error cleared without restart")
  `HRF_ASSERT_SAME(a_err_not_taken, rsp_valid && rsp.error_code != ERR_NONE, !rsp.consumed, "byte consumed with error")
  `HRF_ASSERT_SAME(a_body_taken, rsp_valid && rsp.body_valid, rsp.consumed, "body byte not consumed")
  `HRF_ASSERT_SAME(a_done_clean, phase == PH_DONE, error_flag == ERR_NONE, "error after completion")

endmodule
`default_nettype wire
